### hw/rtl/fixed_point_alu_assert.svh
// Assertion macros shared by the fixed-point ALU checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_alu assertion failed");

// Next-cycle implication, checked out of reset.
`define FPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fixed_point_alu assertion failed");

`endif

### hw/rtl/fpa_pkg.sv
// Package for the fixed-point ALU: command codes, widths and the stage record.
// No dependencies.
package fpa_pkg;

    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_MIN      = 4'd4,
        CMD_MAX      = 4'd5,
        CMD_INC      = 4'd6,
        CMD_DEC      = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_FROM_INT = 4'd9
    } cmd_t;

    // Record carried down the divider chain next to the quotient word.
    typedef struct packed {
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] divisor;
        logic [WORD_W-1:0] rem;
        logic              is_div;
        logic              neg;
        logic              dz;
        logic              lt;
        logic              eq;
    } stage_t;

endpackage

### hw/rtl/fixed_point_alu.sv
// Signed 32-bit fixed-point ALU, top level.
// Depends on fpa_pkg, fpa_prep and fpa_div_cell.
// Takes one transfer per cycle while the output is not stalled; each result
// passes one front stage, then one divider cell per bit of the shifted
// dividend; every command runs through the same chain, so results leave in
// order. A stalled output freezes the whole chain.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [3:0]                        command,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fpa_pkg::WORD_W-1:0] result,
    output logic                              div_by_zero,
    output logic                              a_less_b,
    output logic                              a_equal_b
);

    localparam int W  = fpa_pkg::WORD_W;
    localparam int DW = W + FRAC_BITS;

    logic                              advance;
    logic [DW:0]                       vld_reg;
    fpa_pkg::stage_t                   st [0:DW];
    logic [DW-1:0]                     q  [0:DW];
    fpa_pkg::stage_t                   st_prep;
    fpa_pkg::stage_t                   st_head;
    logic                              is_mul;
    logic signed [fpa_pkg::PROD_W-1:0] prod;
    logic signed [fpa_pkg::PROD_W-1:0] prod_sh;
    logic [W-1:0]                      q_lo;

    assign advance  = !(vld_reg[DW] && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[DW-1:0], in_valid};
        end
    end

    fpa_prep #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_prep (
        .clk        (clk),
        .en         (advance),
        .command    (command),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .st_reg     (st_prep),
        .is_mul_reg (is_mul),
        .prod_reg   (prod),
        .q_reg      (q[0])
    );

    // Scale the registered product on its way into the first cell.
    always_comb
    begin
        prod_sh = prod >>> FRAC_BITS;
        st_head = st_prep;
        if (is_mul)
        begin
            st_head.res = prod_sh[W-1:0];
        end
    end

    assign st[0] = st_head;

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        fpa_div_cell #(.DW(DW)) u_cell (
            .clk    (clk),
            .en     (advance),
            .st_in  (st[i]),
            .q_in   (q[i]),
            .st_reg (st[i+1]),
            .q_reg  (q[i+1])
        );
    end

    always_comb
    begin
        q_lo = st[DW].neg ? (-q[DW][W-1:0]) : q[DW][W-1:0];
        if (st[DW].dz)
        begin
            result = '0;
        end
        else if (st[DW].is_div)
        begin
            result = q_lo;
        end
        else
        begin
            result = st[DW].res;
        end
    end

    assign out_valid   = vld_reg[DW];
    assign div_by_zero = st[DW].dz;
    assign a_less_b    = st[DW].lt;
    assign a_equal_b   = st[DW].eq;

endmodule

### hw/rtl/fpa_prep.sv
// Front stage of the fixed-point ALU: simple ops, the product and divider setup.
// Depends on fpa_pkg.
module fpa_prep #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int DW        = fpa_pkg::WORD_W + FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [3:0]                            command,
    input  logic signed [fpa_pkg::WORD_W-1:0]     operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0]     operand_b,
    output fpa_pkg::stage_t                       st_reg,
    output logic                                  is_mul_reg,
    output logic signed [fpa_pkg::PROD_W-1:0]     prod_reg,
    output logic [DW-1:0]                         q_reg
);

    fpa_pkg::stage_t                   st_next;
    logic                              is_mul_next;
    logic signed [fpa_pkg::PROD_W-1:0] prod_next;
    logic [fpa_pkg::WORD_W-1:0]        abs_a;
    logic [fpa_pkg::WORD_W-1:0]        abs_b;

    always_comb
    begin
        abs_a     = operand_a[fpa_pkg::WORD_W-1] ? (-operand_a) : operand_a;
        abs_b     = operand_b[fpa_pkg::WORD_W-1] ? (-operand_b) : operand_b;
        prod_next = operand_a * operand_b;
        is_mul_next        = 1'b0;
        st_next.res        = '0;
        st_next.divisor    = abs_b;
        st_next.rem        = '0;
        st_next.is_div     = 1'b0;
        st_next.neg        = operand_a[fpa_pkg::WORD_W-1] ^ operand_b[fpa_pkg::WORD_W-1];
        st_next.dz         = 1'b0;
        st_next.lt         = operand_a < operand_b;
        st_next.eq         = operand_a == operand_b;
        case (fpa_pkg::cmd_t'(command))
            fpa_pkg::CMD_ADD:      st_next.res = operand_a + operand_b;
            fpa_pkg::CMD_SUB:      st_next.res = operand_a - operand_b;
            fpa_pkg::CMD_MUL:      is_mul_next = 1'b1;
            fpa_pkg::CMD_DIV:
            begin
                st_next.is_div = 1'b1;
                st_next.dz     = operand_b == '0;
            end
            fpa_pkg::CMD_MIN:      st_next.res = (operand_a < operand_b) ? operand_a : operand_b;
            fpa_pkg::CMD_MAX:      st_next.res = (operand_a > operand_b) ? operand_a : operand_b;
            fpa_pkg::CMD_INC:      st_next.res = operand_a + 1'b1;
            fpa_pkg::CMD_DEC:      st_next.res = operand_a - 1'b1;
            fpa_pkg::CMD_TO_INT:   st_next.res = operand_a >>> FRAC_BITS;
            fpa_pkg::CMD_FROM_INT: st_next.res = operand_a << FRAC_BITS;
            default:               st_next.res = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg     <= st_next;
            is_mul_reg <= is_mul_next;
            prod_reg   <= prod_next;
            q_reg      <= {abs_a, {FRAC_BITS{1'b0}}};
        end
    end

endmodule

### hw/rtl/fpa_div_cell.sv
// One restoring-divide cell: resolves one quotient bit per pass.
// Depends on fpa_pkg.
module fpa_div_cell #(
    parameter int DW = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            en,
    input  fpa_pkg::stage_t st_in,
    input  logic [DW-1:0]   q_in,
    output fpa_pkg::stage_t st_reg,
    output logic [DW-1:0]   q_reg
);

    localparam int W = fpa_pkg::WORD_W;

    fpa_pkg::stage_t st_next;
    logic [W:0]      rem_sh;
    logic [W+1:0]    diff;
    logic            ge;

    always_comb
    begin
        rem_sh = {st_in.rem, q_in[DW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, st_in.divisor};
        ge     = !diff[W+1];
        st_next     = st_in;
        st_next.rem = ge ? diff[W-1:0] : rem_sh[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
            q_reg  <= {q_in[DW-2:0], ge};
        end
    end

endmodule

### hw/rtl/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_assert.svh and fpa_pkg.
`include "fixed_point_alu_assert.svh"

module fpa_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [fpa_pkg::WORD_W-1:0] result,
    input logic                              div_by_zero,
    input logic                              a_less_b,
    input logic                              a_equal_b
);

    `FPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result))
    `FPA_ASSERT_IMPL(a_dz_zero, out_valid && div_by_zero, result == '0)
    `FPA_ASSERT_IMPL(a_flags_excl, out_valid && a_equal_b, !a_less_b)
    `FPA_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);
